// File: hdl/ilf_pkg.sv
// Shared widths, codes and the product schedule of the incremental line fit.
`default_nettype none

package ilf_pkg;

  // Field and state widths
  localparam int SAMPLE_W = 12;  // x and y sample width
  localparam int COUNT_W  = 11;  // point count
  localparam int SX_W     = 23;  // sum of x, sum of y
  localparam int SXX_W    = 34;  // sum of x*x, sum of x*y
  localparam int ACC_W    = 58;  // product accumulator, holds either numerator
  localparam int DEN_W    = 45;  // positive denominator
  localparam int QUO_W    = 33;  // quotient bits developed by the divider
  localparam int Q_W      = 32;  // Q16.16 result
  localparam int FRAC_W   = 16;  // fraction bits of a result

  // Shared multiplier: A operand times one 18-bit slice of the B operand
  localparam int MA_W   = 24;
  localparam int MB_W   = 35;
  localparam int SLICE  = 17;          // bits in the low slice of B
  localparam int MP_W   = MA_W + SLICE + 1;

  // Defaults of the top-level parameters
  localparam int MAX_POINTS_DEF  = 2047;
  localparam int SAMPLE_BITS_DEF = 12;

  // Commands
  localparam logic [1:0] CMD_ADD_XY = 2'd0;
  localparam logic [1:0] CMD_ADD_Y  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FEW     = 2'd1;
  localparam logic [1:0] ST_SAME_X  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Products run through the shared multiplier, in schedule order
  typedef enum logic [2:0] {
    P_XX,      // x*x for the update of sum_xx
    P_XY,      // x*y for the update of sum_xy
    P_NSXX,    // n*sum_xx
    P_SXSX,    // - sum_x*sum_x      -> denominator
    P_NSXY,    // n*sum_xy
    P_SXSY,    // - sum_x*sum_y      -> slope numerator
    P_SYSXX,   // sum_y*sum_xx
    P_SXSXY    // - sum_x*sum_xy     -> intercept numerator
  } prod_t;

  typedef enum logic [1:0] {A_N, A_SX, A_SY, A_X} a_sel_t;
  typedef enum logic [2:0] {B_SXX, B_SXY, B_SX, B_SY, B_X, B_Y} b_sel_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   neg;    // subtract the product from the accumulator
  } mul_op_t;

  // Operand selection for each scheduled product
  function automatic mul_op_t mul_op(input prod_t p);
    mul_op_t op;
    op = '{a_sel: A_X, b_sel: B_X, neg: 1'b0};
    case (p)
      P_XX:    op = '{a_sel: A_X,  b_sel: B_X,   neg: 1'b0};
      P_XY:    op = '{a_sel: A_X,  b_sel: B_Y,   neg: 1'b0};
      P_NSXX:  op = '{a_sel: A_N,  b_sel: B_SXX, neg: 1'b0};
      P_SXSX:  op = '{a_sel: A_SX, b_sel: B_SX,  neg: 1'b1};
      P_NSXY:  op = '{a_sel: A_N,  b_sel: B_SXY, neg: 1'b0};
      P_SXSY:  op = '{a_sel: A_SX, b_sel: B_SY,  neg: 1'b1};
      P_SYSXX: op = '{a_sel: A_SY, b_sel: B_SXX, neg: 1'b0};
      P_SXSXY: op = '{a_sel: A_SX, b_sel: B_SXY, neg: 1'b1};
      default: op = '{a_sel: A_X,  b_sel: B_X,   neg: 1'b0};
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

// File: hdl/incremental_line_fit.sv
// Top level of the incremental least-squares line fit.
`default_nettype none

// Keeps the point count and the exact sums of x, y, x*x and x*y, and after
// every input word returns the least-squares slope and intercept as signed
// Q16.16 (rounded half away from zero, saturated) with a status code. One
// word is worked on at a time; s_axis_tready is high only while the block is
// idle, and a finished result may still wait in the output register while the
// next word is taken. All arithmetic runs through one 24x18 signed multiplier
// (each wide product in two slice passes, each a multiply and an accumulate,
// then a step that acts on the sum) and one 46-bit restoring divider that
// develops one quotient bit per cycle. A clear or a word refused by a full
// store goes straight to the output register; other words update the sums if
// they add a point and then, with at least two points and not all x equal,
// run the fit with its two 33-step divisions. A result that cannot leave
// because the previous one is still waiting is held until that one is taken.
module incremental_line_fit
  import ilf_pkg::*;
#(
  parameter int MAX_POINTS  = MAX_POINTS_DEF,   // 3 .. 2047
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF   // 8 .. 12, low bits of a sample
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [11:0] x_value, [23:12] y_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // [31:0] slope, [63:32] intercept,
                                           // [74:64] points_held, rest zero
  output logic [1:0]       m_axis_tuser    // [1:0] status
);

  localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_STEP, S_FIT, S_DINIT, S_DIV, S_DFIN, S_FIN
  } state_t;

  state_t state;

  // Fit state
  logic        [COUNT_W-1:0] count;
  logic signed [SX_W-1:0]    sum_x, sum_y;
  logic signed [SXX_W-1:0]   sum_xx, sum_xy;

  // Item and working registers
  logic signed [SAMPLE_W-1:0] x_r, y_r;
  prod_t                      prod_idx;
  logic                       hi_pass;
  logic signed [MP_W-1:0]     prod;
  logic signed [ACC_W-1:0]    acc;
  logic        [DEN_W-1:0]    den;
  logic                       div_neg, div_ovf, div_is_slope;
  logic        [DEN_W-1:0]    rem;
  logic        [QUO_W-1:0]    dq;
  logic        [5:0]          div_cnt;
  logic        [Q_W-1:0]      slope_r, icpt_r;
  logic        [1:0]          status_r;

  // Sample extraction from the low SAMPLE_BITS bits
  logic signed [SAMPLE_W-1:0] x_sh, y_sh, x_ext, y_ext;
  logic        [1:0]          cmd_in;

  always_comb begin
    x_sh   = s_axis_tdata[11:0] << SHIFT;
    y_sh   = s_axis_tdata[23:12] << SHIFT;
    x_ext  = x_sh >>> SHIFT;
    y_ext  = y_sh >>> SHIFT;
    cmd_in = s_axis_tuser;
  end

  // Shared multiplier operands
  mul_op_t                 op;
  logic signed [MA_W-1:0]  a_op;
  logic signed [MB_W-1:0]  b_op;
  logic signed [SLICE:0]   b_part;
  logic signed [ACC_W-1:0] prod_ext, prod_sh;

  always_comb begin
    op = mul_op(prod_idx);
    case (op.a_sel)
      A_N:     a_op = MA_W'({1'b0, count});
      A_SX:    a_op = MA_W'(sum_x);
      A_SY:    a_op = MA_W'(sum_y);
      A_X:     a_op = MA_W'(x_r);
      default: a_op = '0;
    endcase
    case (op.b_sel)
      B_SXX:   b_op = MB_W'(sum_xx);
      B_SXY:   b_op = MB_W'(sum_xy);
      B_SX:    b_op = MB_W'(sum_x);
      B_SY:    b_op = MB_W'(sum_y);
      B_X:     b_op = MB_W'(x_r);
      B_Y:     b_op = MB_W'(y_r);
      default: b_op = '0;
    endcase
    // high slice is signed, low slice is zero-extended
    b_part   = hi_pass ? b_op[MB_W-1:SLICE] : $signed({1'b0, b_op[SLICE-1:0]});
    prod_ext = ACC_W'(prod);
    prod_sh  = hi_pass ? (prod_ext <<< SLICE) : prod_ext;
  end

  // Divider datapath
  logic [ACC_W-1:0]         mag;
  logic [ACC_W-SLICE-1:0]   rem_init;
  logic [DEN_W:0]           r2;
  logic [DEN_W+1:0]         diff;
  logic                     round_up;
  logic [QUO_W:0]           q_rnd, q_lim, q_fin;
  logic [Q_W-1:0]           q_res;

  always_comb begin
    mag      = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    rem_init = mag[ACC_W-1:SLICE];
    r2       = {rem, dq[QUO_W-1]};
    diff     = {1'b0, r2} - {2'b00, den};
    round_up = ({rem, 1'b0} >= {1'b0, den});
    q_rnd    = {1'b0, dq} + (QUO_W+1)'(round_up);
    q_lim    = div_neg ? (QUO_W+1)'(34'h080000000) : (QUO_W+1)'(34'h07FFFFFFF);
    q_fin    = (div_ovf || q_rnd > q_lim) ? q_lim : q_rnd;
    q_res    = div_neg ? (~q_fin[Q_W-1:0] + 32'd1) : q_fin[Q_W-1:0];
  end

  assign s_axis_tready = (state == S_IDLE) && !rst;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      count         <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_xx        <= '0;
      sum_xy        <= '0;
    end else begin
      // a taken word empties the output register unless a new one is loaded
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            slope_r  <= '0;
            icpt_r   <= '0;
            y_r      <= y_ext;
            hi_pass  <= 1'b0;
            acc      <= '0;
            if (cmd_in == CMD_CLEAR) begin
              count    <= '0;
              sum_x    <= '0;
              sum_y    <= '0;
              sum_xx   <= '0;
              sum_xy   <= '0;
              status_r <= ST_FEW;
              state    <= S_FIN;
            end else if (cmd_in == CMD_ADD_XY || cmd_in == CMD_ADD_Y) begin
              if (count >= COUNT_W'(MAX_POINTS)) begin
                status_r <= ST_FULL;
                state    <= S_FIN;
              end else begin
                x_r      <= (cmd_in == CMD_ADD_Y) ? $signed({1'b0, count + 11'd1})
                                                  : x_ext;
                prod_idx <= P_XX;
                state    <= S_MUL;
              end
            end else begin
              state <= S_FIT;
            end
          end
        end

        // one slice product, registered
        S_MUL: begin
          prod  <= a_op * b_part;
          state <= S_ACC;
        end

        S_ACC: begin
          acc <= op.neg ? (acc - prod_sh) : (acc + prod_sh);
          if (!hi_pass) begin
            hi_pass <= 1'b1;
            state   <= S_MUL;
          end else begin
            hi_pass <= 1'b0;
            state   <= S_STEP;
          end
        end

        // act on a finished product
        S_STEP: begin
          case (prod_idx)
            P_XX: begin
              sum_xx   <= sum_xx + acc[SXX_W-1:0];
              acc      <= '0;
              prod_idx <= P_XY;
              state    <= S_MUL;
            end
            P_XY: begin
              sum_xy <= sum_xy + acc[SXX_W-1:0];
              sum_x  <= sum_x + SX_W'(x_r);
              sum_y  <= sum_y + SX_W'(y_r);
              count  <= count + 11'd1;
              state  <= S_FIT;
            end
            P_SXSX: begin
              if (acc[ACC_W-1] || acc == '0) begin
                status_r <= ST_SAME_X;
                state    <= S_FIN;
              end else begin
                den      <= acc[DEN_W-1:0];
                acc      <= '0;
                prod_idx <= P_NSXY;
                state    <= S_MUL;
              end
            end
            P_SXSY: begin
              div_is_slope <= 1'b1;
              state        <= S_DINIT;
            end
            P_SXSXY: begin
              div_is_slope <= 1'b0;
              state        <= S_DINIT;
            end
            P_NSXX: begin
              prod_idx <= P_SXSX;
              state    <= S_MUL;
            end
            P_NSXY: begin
              prod_idx <= P_SXSY;
              state    <= S_MUL;
            end
            P_SYSXX: begin
              prod_idx <= P_SXSXY;
              state    <= S_MUL;
            end
            default: state <= S_FIN;
          endcase
        end

        // points in hand: enough for a fit?
        S_FIT: begin
          if (count < 11'd2) begin
            status_r <= ST_FEW;
            state    <= S_FIN;
          end else begin
            acc      <= '0;
            prod_idx <= P_NSXX;
            state    <= S_MUL;
          end
        end

        // dividend magnitude; high bits beyond the quotient range mean overflow
        S_DINIT: begin
          div_neg <= acc[ACC_W-1];
          div_ovf <= ({4'b0, rem_init} >= den);
          rem     <= DEN_W'(rem_init);
          dq      <= {mag[SLICE-1:0], 16'b0};
          div_cnt <= 6'(QUO_W);
          state   <= S_DIV;
        end

        // one restoring step per cycle, quotient shifts in as dividend shifts out
        S_DIV: begin
          if (!diff[DEN_W+1]) begin
            rem <= diff[DEN_W-1:0];
          end else begin
            rem <= r2[DEN_W-1:0];
          end
          dq      <= {dq[QUO_W-2:0], !diff[DEN_W+1]};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) begin
            state <= S_DFIN;
          end
        end

        // round, saturate, sign
        S_DFIN: begin
          if (div_is_slope) begin
            slope_r  <= q_res;
            acc      <= '0;
            prod_idx <= P_SYSXX;
            state    <= S_MUL;
          end else begin
            icpt_r   <= q_res;
            status_r <= ST_OK;
            state    <= S_FIN;
          end
        end

        // hand the result word to the output register
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {5'b0, count, icpt_r, slope_r};
            m_axis_tuser  <= status_r;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
